// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the heatmap local maximum finder.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/hmlm_pkg.sv
// Package of the heatmap local maximum finder: default sizes, register codes,
// field widths and the neighbor mask type. No dependencies.
package hmlm_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEF_MAX_LINE_LENGTH = 64;
  localparam int DEF_MAX_LINES       = 256;
  localparam int DEF_SAMPLE_BITS     = 16;

  // Fixed field and register widths.
  localparam int THR_W      = 16;
  localparam int LCNT_W     = 9;
  localparam int LLEN_W     = 7;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int PEAK_X_W   = 8;
  localparam int PEAK_Y_W   = 6;

  // Register reset values.
  localparam logic [THR_W-1:0]  THR_RESET  = 16'd0;
  localparam logic [LCNT_W-1:0] LCNT_RESET = 9'd64;
  localparam logic [LLEN_W-1:0] LLEN_RESET = 7'd44;

  // Stored window columns: the candidate center and its left neighbor.
  localparam int WIN_COLS = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD   = 2'd0,
    CFG_LINE_COUNT  = 2'd1,
    CFG_LINE_LENGTH = 2'd2
  } cfg_reg_t;

  // Which neighbors of the center lie inside the frame.
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } nbr_mask_t;

endpackage

// File: hw/rtl/hmlm_line_buf.sv
// Line buffer of the local maximum finder: holds the two previous lines as
// pairs {older, newer}, one pair per position. Registered read, write bypass.
module hmlm_line_buf #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; a write to the same position in this cycle is passed through.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/hmlm_cell.sv
// One window cell of the local maximum finder: stores a column of three
// samples with its coordinates and a valid flag, and passes it on when shifted.
module hmlm_cell #(
  parameter int COL_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift_en,
  input  logic [COL_W-1:0] col_in,
  input  logic             ok_in,
  output logic [COL_W-1:0] col_out,
  output logic             ok_out
);

  logic [COL_W-1:0] col_r;
  logic             ok_r;

  // The valid flag is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b0;
    end else if (shift_en) begin
      ok_r <= ok_in;
    end
  end

  // Column payload.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;
  assign ok_out  = ok_r;

endmodule

// File: hw/rtl/hmlm_peak_test.sv
// Neighborhood test of the local maximum finder: compares the center against
// the threshold and its in-frame neighbors. Depends on hmlm_pkg.
module hmlm_peak_test #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic signed [hmlm_pkg::THR_W-1:0] threshold,
  input  logic signed [SAMPLE_BITS-1:0]     cen_mid,
  input  logic signed [SAMPLE_BITS-1:0]     cen_top,
  input  logic signed [SAMPLE_BITS-1:0]     cen_bot,
  input  logic signed [SAMPLE_BITS-1:0]     lft_mid,
  input  logic signed [SAMPLE_BITS-1:0]     lft_top,
  input  logic signed [SAMPLE_BITS-1:0]     lft_bot,
  input  logic signed [SAMPLE_BITS-1:0]     rgt_mid,
  input  logic signed [SAMPLE_BITS-1:0]     rgt_top,
  input  logic signed [SAMPLE_BITS-1:0]     rgt_bot,
  input  hmlm_pkg::nbr_mask_t               nbr,
  input  logic                              cand_ok,
  output logic                              peak
);

  localparam int CmpW = (SAMPLE_BITS > hmlm_pkg::THR_W) ? SAMPLE_BITS : hmlm_pkg::THR_W;

  logic signed [CmpW-1:0] v_ext;
  logic signed [CmpW-1:0] thr_ext;
  logic above;
  logic col_ok;
  logic lft_ok;
  logic rgt_ok;

  assign v_ext   = CmpW'(cen_mid);
  assign thr_ext = CmpW'(threshold);
  assign above   = v_ext > thr_ext;

  // Up and left-column neighbors must be lower, the rest lower or equal.
  assign col_ok = (!nbr.up || (cen_top < cen_mid)) && (!nbr.down || (cen_bot <= cen_mid));

  assign lft_ok = !nbr.left ||
                  ((lft_mid < cen_mid) &&
                   (!nbr.up   || (lft_top < cen_mid)) &&
                   (!nbr.down || (lft_bot < cen_mid)));

  assign rgt_ok = !nbr.right ||
                  ((rgt_mid <= cen_mid) &&
                   (!nbr.up   || (rgt_top <= cen_mid)) &&
                   (!nbr.down || (rgt_bot <= cen_mid)));

  assign peak = cand_ok && above && col_ok && lft_ok && rgt_ok;

endmodule

// File: hw/rtl/heatmap_local_maximum_finder.sv
// A maximum is registered onto out_ as the sample that decides it leaves the second stage.
// That sample is the next one in the following line, or for the last position of a line
// the first sample of the line after next. Throughput: one sample per cycle, as the line
// buffer reads and writes once and the window shifts once; a maximum held at a busy out_ stalls.
// Reset (synchronous, rst_n low) clears counters, valid flags and config registers to defaults;
// the line buffer is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module heatmap_local_maximum_finder #(
  parameter int MAX_LINE_LENGTH = hmlm_pkg::DEF_MAX_LINE_LENGTH,
  parameter int MAX_LINES       = hmlm_pkg::DEF_MAX_LINES,
  parameter int SAMPLE_BITS     = hmlm_pkg::DEF_SAMPLE_BITS,
  localparam int InW  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OutW = ((hmlm_pkg::PEAK_X_W + hmlm_pkg::PEAK_Y_W + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input requests.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [InW-1:0]                     in_tdata,   // sample
  // Result requests.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [OutW-1:0]                    out_tdata,  // peak_y (high), peak_x (low)
  // Configuration writes.
  input  logic                               cfg_we,
  input  logic [hmlm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hmlm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int SB    = SAMPLE_BITS;
  localparam int YW    = (MAX_LINE_LENGTH > 1) ? $clog2(MAX_LINE_LENGTH) : 1;
  localparam int XW    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int ColW  = 3 * SB + XW + YW;
  localparam int OffX  = 3 * SB;
  localparam int OffY  = 3 * SB + XW;
  localparam int PairW = 2 * SB;
  localparam int Cols  = hmlm_pkg::WIN_COLS;

  // Configuration registers.
  logic signed [hmlm_pkg::THR_W-1:0] threshold_r;
  logic [hmlm_pkg::LCNT_W-1:0]       line_count_r;
  logic [hmlm_pkg::LLEN_W-1:0]       line_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= hmlm_pkg::THR_RESET;
      line_count_r  <= hmlm_pkg::LCNT_RESET;
      line_length_r <= hmlm_pkg::LLEN_RESET;
    end else if (cfg_we) begin
      unique case (hmlm_pkg::cfg_reg_t'(cfg_index))
        hmlm_pkg::CFG_THRESHOLD:   threshold_r   <= cfg_wdata[hmlm_pkg::THR_W-1:0];
        hmlm_pkg::CFG_LINE_COUNT:  line_count_r  <= cfg_wdata[hmlm_pkg::LCNT_W-1:0];
        hmlm_pkg::CFG_LINE_LENGTH: line_length_r <= cfg_wdata[hmlm_pkg::LLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame extents: zero acts as one, large values clamp to the maximum.
  logic [XW:0] eff_n;
  logic [YW:0] eff_len;

  always_comb begin
    if (line_count_r == '0) begin
      eff_n = (XW+1)'(1);
    end else if (32'(line_count_r) > MAX_LINES) begin
      eff_n = (XW+1)'(MAX_LINES);
    end else begin
      eff_n = (XW+1)'(line_count_r);
    end
    if (line_length_r == '0) begin
      eff_len = (YW+1)'(1);
    end else if (32'(line_length_r) > MAX_LINE_LENGTH) begin
      eff_len = (YW+1)'(MAX_LINE_LENGTH);
    end else begin
      eff_len = (YW+1)'(line_length_r);
    end
  end

  // Handshake of the two stages.
  logic in_fire;
  logic b_fire;
  logic b_valid_r;
  logic peak;
  logic out_tvalid_r;

  assign in_fire   = in_tvalid && in_tready;
  assign b_fire    = b_valid_r && (!peak || !out_tvalid_r || out_tready);
  assign in_tready = !b_valid_r || b_fire;

  // Position counters of the next sample.
  logic [XW-1:0] line_idx_r, line_idx_nxt;
  logic [YW-1:0] samp_idx_r, samp_idx_nxt;
  logic          primed_r, primed_nxt;
  logic          y_last;
  logic          x_last;
  logic          x_over;
  logic [XW-1:0] new_col_x;
  logic          new_ok;

  assign y_last    = ({1'b0, samp_idx_r} + (YW+1)'(1)) >= eff_len;
  assign x_last    = ({1'b0, line_idx_r} + (XW+1)'(1)) >= eff_n;
  assign x_over    = {1'b0, line_idx_r} >= eff_n;
  assign new_col_x = (line_idx_r != '0) ? line_idx_r - XW'(1) : XW'(eff_n - (XW+1)'(1));
  assign new_ok    = (line_idx_r != '0) || primed_r;

  always_comb begin
    samp_idx_nxt = samp_idx_r;
    line_idx_nxt = line_idx_r;
    primed_nxt   = primed_r;
    if (in_fire) begin
      if (y_last) begin
        samp_idx_nxt = '0;
        primed_nxt   = 1'b1;
        line_idx_nxt = x_last ? '0 : line_idx_r + XW'(1);
      end else begin
        samp_idx_nxt = samp_idx_r + YW'(1);
        if (x_over) begin
          line_idx_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samp_idx_r <= '0;
      line_idx_r <= '0;
      primed_r   <= 1'b0;
    end else begin
      samp_idx_r <= samp_idx_nxt;
      line_idx_r <= line_idx_nxt;
      primed_r   <= primed_nxt;
    end
  end

  // Second stage: the accepted sample waits here for its line buffer column.
  logic signed [SB-1:0] b_sample_r;
  logic [XW-1:0]        b_x_r;
  logic [YW-1:0]        b_y_r;
  logic                 b_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (in_fire) begin
      b_valid_r <= 1'b1;
    end else if (b_fire) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_sample_r <= in_tdata[SB-1:0];
      b_x_r      <= new_col_x;
      b_y_r      <= samp_idx_r;
      b_ok_r     <= new_ok;
    end
  end

  // Line buffer: read on accept, rotate {older, newer} when the column moves on.
  logic [PairW-1:0]     rd_pair;
  logic signed [SB-1:0] rd_older;
  logic signed [SB-1:0] rd_newer;

  assign rd_older = rd_pair[PairW-1:SB];
  assign rd_newer = rd_pair[SB-1:0];

  hmlm_line_buf #(
    .DEPTH (MAX_LINE_LENGTH),
    .WIDTH (PairW)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (samp_idx_r),
    .wr_en   (b_fire),
    .wr_addr (b_y_r),
    .wr_data ({rd_newer, b_sample_r}),
    .rd_data (rd_pair)
  );

  // Window chain: the new column enters, the first cell holds the center candidate
  // and the second its left neighbor.
  logic [ColW-1:0] col_chain [Cols+1];
  logic [Cols:0]   ok_chain;

  assign col_chain[0] = {b_y_r, b_x_r, b_sample_r, rd_newer, rd_older};
  assign ok_chain[0]  = b_ok_r;

  for (genvar i = 0; i < Cols; i++) begin : g_win
    hmlm_cell #(
      .COL_W (ColW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (b_fire),
      .col_in   (col_chain[i]),
      .ok_in    (ok_chain[i]),
      .col_out  (col_chain[i+1]),
      .ok_out   (ok_chain[i+1])
    );
  end

  // Unpack center and left columns.
  logic signed [SB-1:0] cen_top, cen_mid, cen_bot;
  logic signed [SB-1:0] lft_top, lft_mid, lft_bot;
  logic [XW-1:0]        cen_x;
  logic [YW-1:0]        cen_y;

  assign cen_top = col_chain[1][SB-1:0];
  assign cen_mid = col_chain[1][2*SB-1:SB];
  assign cen_bot = col_chain[1][3*SB-1:2*SB];
  assign cen_x   = col_chain[1][OffX+XW-1:OffX];
  assign cen_y   = col_chain[1][OffY+YW-1:OffY];
  assign lft_top = col_chain[2][SB-1:0];
  assign lft_mid = col_chain[2][2*SB-1:SB];
  assign lft_bot = col_chain[2][3*SB-1:2*SB];

  // Neighbors inside the frame; the right column exists only within a line.
  hmlm_pkg::nbr_mask_t nbr;

  assign nbr.up    = cen_x != '0;
  assign nbr.down  = ({1'b0, cen_x} + (XW+1)'(1)) < eff_n;
  assign nbr.left  = cen_y != '0;
  assign nbr.right = (b_y_r != '0) && (({1'b0, cen_y} + (YW+1)'(1)) < eff_len);

  hmlm_peak_test #(
    .SAMPLE_BITS (SB)
  ) u_peak_test (
    .threshold (threshold_r),
    .cen_mid   (cen_mid),
    .cen_top   (cen_top),
    .cen_bot   (cen_bot),
    .lft_mid   (lft_mid),
    .lft_top   (lft_top),
    .lft_bot   (lft_bot),
    .rgt_mid   (rd_newer),
    .rgt_top   (rd_older),
    .rgt_bot   (b_sample_r),
    .nbr       (nbr),
    .cand_ok   (ok_chain[1]),
    .peak      (peak)
  );

  // Output register.
  logic [hmlm_pkg::PEAK_X_W+hmlm_pkg::PEAK_Y_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (b_fire && peak) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && peak) begin
      out_data_r <= {hmlm_pkg::PEAK_Y_W'(cen_y), hmlm_pkg::PEAK_X_W'(cen_x)};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OutW'(out_data_r);

  // An accepted sample always occupies the second stage in the next cycle.
  `ASSERT_NEXT(a_accept_fills_stage, in_fire, b_valid_r, "accepted sample was lost")
  // The window chain moves each valid flag one cell along on every shift.
  `ASSERT_NEXT(a_chain_shift, b_fire, ok_chain[2] == $past(ok_chain[1]), "window did not shift")
  // A new result appears only after a peak was found in a moving stage.
  `ASSERT_IMPLY(a_result_source, $rose(out_tvalid_r), $past(b_fire && peak), "spurious result")

endmodule
